/* hdl/pal_pkg.sv */
`default_nettype none
package pal_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int FIELD_W  = 7;
   localparam int WORD_W   = 32;
   localparam int CMP_W    = ((CNT_W > FIELD_W) ? CNT_W : FIELD_W) + 1;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_FIND   = 2'd2,
      OP_FILL   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_PUT,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type                     op;
      logic signed [WORD_W-1:0]   value;
      logic        [FIELD_W-1:0]  position;
      logic        [FIELD_W-1:0]  fill_count;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic [FIELD_W-1:0]  found_position;
      logic [FIELD_W-1:0]  list_length;
   } rsp_type;

endpackage
`default_nettype wire

/* hdl/pal_req_if.sv */
`default_nettype none
interface pal_req_if;
   logic              valid;
   logic              ready;
   pal_pkg::req_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/pal_rsp_if.sv */
`default_nettype none
interface pal_rsp_if;
   logic              valid;
   logic              ready;
   pal_pkg::rsp_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/positional_array_list_unit.sv */
// Ordered list of up to 64 signed 32-bit words held in one single-port-read,
// single-port-write memory, with insert, delete, find and fill ascending. One
// command is worked at a time and gives one response beat. The memory moves
// one word per cycle: insert and delete move the entries behind the position,
// find reads from the start up to the first match or through the whole length,
// fill writes fill_count words, and rejected commands go straight to the
// response. A new command is taken while the previous response still waits on
// the output register. Entry storage needs no clearing after reset: only
// entries below the length are read.
`default_nettype none
module positional_array_list_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   pal_req_if.sink    req_ch,
   pal_rsp_if.source  rsp_ch
);

   localparam int AW = pal_pkg::ADDR_W;
   localparam int CW = pal_pkg::CNT_W;
   localparam int MW = pal_pkg::CMP_W;
   localparam int FW = pal_pkg::FIELD_W;
   localparam int WW = pal_pkg::WORD_W;

   pal_pkg::state_type  state_ff, state_in;
   pal_pkg::op_type     op_ff, op_in;
   logic [CW-1:0]       len_ff, len_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [AW-1:0]       tgt_ff, tgt_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       pend_addr_ff, pend_addr_in;
   logic [WW-1:0]       value_ff, value_in;
   logic                ok_ff, ok_in;
   logic [FW-1:0]       found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pal_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic [WW-1:0]       mem [pal_pkg::CAPACITY];
   logic [WW-1:0]       rd_data_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [WW-1:0]       mem_wdata;

   logic                req_fire;
   logic [MW-1:0]       pos_w, len_w, cap_w, cnt_w;

   assign req_ch.ready = (state_ff == pal_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   assign pos_w = MW'(req_ch.data.position);
   assign cnt_w = MW'(req_ch.data.fill_count);
   assign len_w = MW'(len_ff);
   assign cap_w = MW'(pal_pkg::CAPACITY);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[addr_ff];
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      addr_in      = addr_ff;
      tgt_in       = tgt_ff;
      pend_in      = 1'b0;
      pend_addr_in = addr_ff;
      value_in     = value_ff;
      ok_in        = ok_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = value_ff;

      case (state_ff)
         pal_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_ch.data.op;
               value_in = req_ch.data.value;
               ok_in    = 1'b0;
               found_in = '0;
               state_in = pal_pkg::ST_DONE;
               case (req_ch.data.op)
                  pal_pkg::OP_INSERT: begin
                     if (pos_w != '0 && pos_w <= len_w + MW'(1) && len_w < cap_w) begin
                        rem_in   = CW'(len_w - pos_w + MW'(1));
                        addr_in  = AW'(len_w - MW'(1));
                        tgt_in   = AW'(pos_w - MW'(1));
                        state_in = pal_pkg::ST_WALK;
                     end
                  end
                  pal_pkg::OP_DELETE: begin
                     if (pos_w != '0 && pos_w <= len_w) begin
                        rem_in   = CW'(len_w - pos_w);
                        addr_in  = AW'(pos_w);
                        state_in = pal_pkg::ST_WALK;
                     end
                  end
                  pal_pkg::OP_FIND: begin
                     rem_in   = len_ff;
                     addr_in  = '0;
                     state_in = pal_pkg::ST_WALK;
                  end
                  default: begin
                     if (cnt_w <= cap_w) begin
                        rem_in   = CW'(cnt_w);
                        len_in   = CW'(cnt_w);
                        addr_in  = '0;
                        state_in = pal_pkg::ST_FILL;
                     end
                  end
               endcase
            end
         end

         pal_pkg::ST_WALK: begin
            if (rem_ff != '0) begin
               pend_in      = 1'b1;
               pend_addr_in = addr_ff;
               rem_in       = rem_ff - CW'(1);
               addr_in      = (op_ff == pal_pkg::OP_INSERT) ? addr_ff - AW'(1)
                                                             : addr_ff + AW'(1);
            end
            if (pend_ff) begin
               case (op_ff)
                  pal_pkg::OP_INSERT: begin
                     mem_we    = 1'b1;
                     mem_waddr = pend_addr_ff + AW'(1);
                     mem_wdata = rd_data_ff;
                  end
                  pal_pkg::OP_DELETE: begin
                     mem_we    = 1'b1;
                     mem_waddr = pend_addr_ff - AW'(1);
                     mem_wdata = rd_data_ff;
                  end
                  default: begin
                     if (rd_data_ff == value_ff) begin
                        ok_in    = 1'b1;
                        found_in = FW'(CW'(pend_addr_ff) + CW'(1));
                        pend_in  = 1'b0;
                        state_in = pal_pkg::ST_DONE;
                     end
                  end
               endcase
            end else if (rem_ff == '0) begin
               case (op_ff)
                  pal_pkg::OP_INSERT: begin
                     state_in = pal_pkg::ST_PUT;
                  end
                  pal_pkg::OP_DELETE: begin
                     len_in   = len_ff - CW'(1);
                     ok_in    = 1'b1;
                     state_in = pal_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = pal_pkg::ST_DONE;
                  end
               endcase
            end
         end

         pal_pkg::ST_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = tgt_ff;
            mem_wdata = value_ff;
            len_in    = len_ff + CW'(1);
            ok_in     = 1'b1;
            state_in  = pal_pkg::ST_DONE;
         end

         pal_pkg::ST_FILL: begin
            if (rem_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = addr_ff;
               mem_wdata = WW'(addr_ff);
               addr_in   = addr_ff + AW'(1);
               rem_in    = rem_ff - CW'(1);
            end else begin
               ok_in    = 1'b1;
               state_in = pal_pkg::ST_DONE;
            end
         end

         pal_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.ok             = ok_ff;
               rsp_data_in.found_position = found_ff;
               rsp_data_in.list_length    = FW'(len_ff);
               state_in                   = pal_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pal_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pal_pkg::ST_IDLE;
         len_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      rem_ff       <= rem_in;
      addr_ff      <= addr_in;
      tgt_ff       <= tgt_in;
      pend_addr_ff <= pend_addr_in;
      value_ff     <= value_in;
      ok_ff        <= ok_in;
      found_ff     <= found_in;
      rsp_data_ff  <= rsp_data_in;
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      MW'(len_ff) <= MW'(pal_pkg::CAPACITY))
      else $error("list length above capacity");

   a_pend_walk: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == pal_pkg::ST_WALK)
      else $error("memory read pending outside walk");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == pal_pkg::ST_WALK |-> rem_ff <= len_ff)
      else $error("walk count above list length");

   a_put_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == pal_pkg::ST_PUT |=> len_ff == $past(len_ff) + CW'(1))
      else $error("insert did not grow the list");

endmodule
`default_nettype wire
